// ===== rtl/core/aut_pkg.sv =====
// ----------------------------------------------------------------------------
// aut_pkg
// Shared constants and types for the allocation usage tracker.
// ----------------------------------------------------------------------------
package aut_pkg;

  // table and datapath sizing
  localparam int TABLE_ENTRIES = 64;
  localparam int BYTE_BITS     = 48;
  localparam int HANDLE_BITS   = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified operation
  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_FREE_NULL = 2'd2
  } op_t;

  // one classified command
  typedef struct packed {
    op_t                    op;
    logic [HANDLE_BITS-1:0] handle;
    logic [BYTE_BITS-1:0]   bytes;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_APPLY  = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

endpackage

// ===== rtl/core/aut_front.sv =====
// ----------------------------------------------------------------------------
// aut_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module aut_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_mode,
  input  logic [aut_pkg::HANDLE_BITS-1:0] in_alloc_handle,
  input  logic [aut_pkg::BYTE_BITS-1:0]   in_alloc_bytes,
  output logic                            cmd_valid,
  output aut_pkg::cmd_t                   cmd,
  input  logic                            cmd_take
);

  aut_pkg::cmd_t                q_r [aut_pkg::QUEUE_DEPTH];
  logic [aut_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [aut_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [aut_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  aut_pkg::cmd_t                cls;
  logic                         do_push;
  logic                         do_pop;

  // classify the incoming transaction
  always_comb begin
    cls.handle = in_alloc_handle;
    cls.bytes  = in_alloc_bytes;
    if (!in_mode) begin
      cls.op = aut_pkg::OP_ALLOC;
    end else if (in_alloc_handle == '0) begin
      cls.op = aut_pkg::OP_FREE_NULL;
    end else begin
      cls.op = aut_pkg::OP_FREE;
    end
  end

  assign in_full   = (cnt_r == aut_pkg::QCNT_W'(aut_pkg::QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_take && cmd_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == aut_pkg::QPTR_W'(aut_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == aut_pkg::QPTR_W'(aut_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/core/aut_back.sv =====
// ----------------------------------------------------------------------------
// aut_back
// Scans the handle table, updates totals and limit state, holds the result.
// ----------------------------------------------------------------------------
module aut_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  aut_pkg::cmd_t                 cmd,
  output logic                          cmd_take,
  input  logic                          cfg_wr_en,
  input  logic [aut_pkg::BYTE_BITS-1:0] cfg_wr_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [aut_pkg::BYTE_BITS-1:0] out_total_bytes,
  output logic [aut_pkg::BYTE_BITS-1:0] out_peak_bytes,
  output logic                          out_over_limit_event,
  output logic                          out_handle_found,
  output logic                          out_table_overflow
);

  localparam logic [aut_pkg::IDX_W-1:0]     LAST_IDX = aut_pkg::IDX_W'(aut_pkg::TABLE_ENTRIES - 1);
  localparam logic [aut_pkg::BYTE_BITS-1:0] BYTE_MAX = '1;

  // table memories and valid bits
  logic [aut_pkg::HANDLE_BITS-1:0] slot_handle_mem [aut_pkg::TABLE_ENTRIES];
  logic [aut_pkg::BYTE_BITS-1:0]   slot_bytes_mem  [aut_pkg::TABLE_ENTRIES];
  logic [aut_pkg::TABLE_ENTRIES-1:0] slot_valid_r;

  aut_pkg::state_t state_r, state_nxt;
  aut_pkg::cmd_t   cur_r;

  // scan control
  logic [aut_pkg::IDX_W-1:0]       scan_idx_r;
  logic                            issue_r;
  logic                            cmp_v_r;
  logic [aut_pkg::IDX_W-1:0]       cmp_idx_r;
  logic [aut_pkg::HANDLE_BITS-1:0] rd_handle_r;
  logic [aut_pkg::BYTE_BITS-1:0]   rd_bytes_r;
  logic                            found_r;
  logic [aut_pkg::IDX_W-1:0]       found_idx_r;
  logic [aut_pkg::BYTE_BITS-1:0]   found_bytes_r;
  logic                            free_have_r;
  logic [aut_pkg::IDX_W-1:0]       free_idx_r;
  logic                            scan_done;

  // totals and limit
  logic [aut_pkg::BYTE_BITS-1:0] held_r;
  logic [aut_pkg::BYTE_BITS-1:0] peak_r;
  logic [aut_pkg::BYTE_BITS-1:0] limit_r;
  logic                          warned_r;
  logic                          res_ovf_r;
  logic [aut_pkg::BYTE_BITS:0]   sum;
  logic [aut_pkg::BYTE_BITS-1:0] peak_new;
  logic                          fire_event;

  // write port
  logic                          mem_we;
  logic [aut_pkg::IDX_W-1:0]     mem_wa;

  // result register
  logic                          out_vld_r;
  logic                          out_load;

  assign scan_done = cmp_v_r && (cmp_idx_r == LAST_IDX);
  assign out_load  = (state_r == aut_pkg::ST_FINISH) && (!out_vld_r || out_pop);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    cmd_take  = 1'b0;
    unique case (state_r)
      aut_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take  = 1'b1;
          state_nxt = (cmd.op == aut_pkg::OP_FREE_NULL) ? aut_pkg::ST_APPLY : aut_pkg::ST_SCAN;
        end
      end
      aut_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = aut_pkg::ST_APPLY;
        end
      end
      aut_pkg::ST_APPLY: begin
        state_nxt = aut_pkg::ST_FINISH;
      end
      aut_pkg::ST_FINISH: begin
        if (out_load) begin
          state_nxt = aut_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aut_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aut_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latch the command being worked on
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_r <= cmd;
    end
  end

  // scan address counter and compare-stage tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r    <= 1'b0;
      cmp_v_r    <= 1'b0;
      scan_idx_r <= '0;
      cmp_idx_r  <= '0;
    end else begin
      cmp_v_r   <= issue_r;
      cmp_idx_r <= scan_idx_r;
      if (cmd_take && (cmd.op != aut_pkg::OP_FREE_NULL)) begin
        issue_r    <= 1'b1;
        scan_idx_r <= '0;
      end else if (issue_r) begin
        if (scan_idx_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
    end
  end

  // registered table read at the scan address
  always_ff @(posedge clk) begin
    rd_handle_r <= slot_handle_mem[scan_idx_r];
    rd_bytes_r  <= slot_bytes_mem[scan_idx_r];
  end

  // match and empty-slot tracking: lowest index wins
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      found_r     <= 1'b0;
      free_have_r <= 1'b0;
    end else if (cmp_v_r) begin
      if (slot_valid_r[cmp_idx_r] && (rd_handle_r == cur_r.handle) && !found_r) begin
        found_r       <= 1'b1;
        found_idx_r   <= cmp_idx_r;
        found_bytes_r <= rd_bytes_r;
      end
      if (!slot_valid_r[cmp_idx_r] && !free_have_r) begin
        free_have_r <= 1'b1;
        free_idx_r  <= cmp_idx_r;
      end
    end
  end

  // table write decision
  always_comb begin
    mem_we = 1'b0;
    mem_wa = found_idx_r;
    if ((state_r == aut_pkg::ST_APPLY) && (cur_r.op == aut_pkg::OP_ALLOC)) begin
      if (found_r) begin
        mem_we = 1'b1;
      end else if (free_have_r) begin
        mem_we = 1'b1;
        mem_wa = free_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_handle_mem[mem_wa] <= cur_r.handle;
      slot_bytes_mem[mem_wa]  <= cur_r.bytes;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (mem_we) begin
      slot_valid_r[mem_wa] <= 1'b1;
    end else if ((state_r == aut_pkg::ST_APPLY) && (cur_r.op == aut_pkg::OP_FREE) && found_r) begin
      slot_valid_r[found_idx_r] <= 1'b0;
    end
  end

  // saturating add, peak and limit checks
  assign sum        = {1'b0, held_r} + {1'b0, cur_r.bytes};
  assign peak_new   = (held_r > peak_r) ? held_r : peak_r;
  assign fire_event = (cur_r.op == aut_pkg::OP_ALLOC) && (limit_r != '0) &&
                      (held_r > limit_r) && !warned_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      peak_r   <= '0;
      limit_r  <= '0;
      warned_r <= 1'b0;
    end else begin
      if (state_r == aut_pkg::ST_APPLY) begin
        if (cur_r.op == aut_pkg::OP_ALLOC) begin
          held_r <= sum[aut_pkg::BYTE_BITS] ? BYTE_MAX : sum[aut_pkg::BYTE_BITS-1:0];
        end else if ((cur_r.op == aut_pkg::OP_FREE) && found_r) begin
          held_r <= (found_bytes_r >= held_r) ? '0 : held_r - found_bytes_r;
        end
      end
      if (out_load) begin
        peak_r <= peak_new;
      end
      if (cfg_wr_en) begin
        limit_r  <= cfg_wr_data;
        warned_r <= 1'b0;
      end else if (out_load && fire_event) begin
        warned_r <= 1'b1;
      end
    end
  end

  // overflow flag for the result
  always_ff @(posedge clk) begin
    if (state_r == aut_pkg::ST_APPLY) begin
      res_ovf_r <= (cur_r.op == aut_pkg::OP_ALLOC) && !found_r && !free_have_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total_bytes      <= held_r;
      out_peak_bytes       <= peak_new;
      out_over_limit_event <= fire_event;
      out_handle_found     <= found_r && (cur_r.op != aut_pkg::OP_FREE_NULL);
      out_table_overflow   <= res_ovf_r;
    end
  end

  assign out_empty = !out_vld_r;

  // checks
  a_peak_ge_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_peak_bytes >= out_total_bytes))
    else $error("peak below total in result");

  a_ovf_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_table_overflow && out_handle_found))
    else $error("overflow reported for a handle already present");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> (cmd_valid && (state_r == aut_pkg::ST_IDLE)))
    else $error("command taken while busy or queue empty");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == aut_pkg::ST_FINISH))
    else $error("result appeared outside finish step");

endmodule

// ===== rtl/core/allocation_usage_tracker_core.sv =====
// ----------------------------------------------------------------------------
// allocation_usage_tracker_core
// Tracks bytes held by outstanding allocations, the peak and a soft limit.
//
//   channel  handshake              payload
//   in       in_push / in_full      in_mode, in_alloc_handle, in_alloc_bytes
//   out      out_pop / out_empty    out_total_bytes, out_peak_bytes,
//                                   out_over_limit_event, out_handle_found,
//                                   out_table_overflow
//   cfg      cfg_wr_en              cfg_wr_data (soft limit)
//
// An allocation or a free of a non-null handle passes through the command take,
// a scan with one table read per cycle over the single read port of the handle
// memory, one compare stage, an update step and a result step. A free of the
// null handle skips the scan.
// Synchronous active-low reset clears the valid bits, totals and limit at once.
// A two-entry command queue keeps accepting, until it is full, while the result register waits.
// ----------------------------------------------------------------------------
module allocation_usage_tracker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_mode,
  input  logic [aut_pkg::HANDLE_BITS-1:0] in_alloc_handle,
  input  logic [aut_pkg::BYTE_BITS-1:0]   in_alloc_bytes,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [aut_pkg::BYTE_BITS-1:0]   out_total_bytes,
  output logic [aut_pkg::BYTE_BITS-1:0]   out_peak_bytes,
  output logic                            out_over_limit_event,
  output logic                            out_handle_found,
  output logic                            out_table_overflow,
  input  logic                            cfg_wr_en,
  input  logic [aut_pkg::BYTE_BITS-1:0]   cfg_wr_data
);

  logic          cmd_valid;
  logic          cmd_take;
  aut_pkg::cmd_t cmd;

  // intake and classification
  aut_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_alloc_handle (in_alloc_handle),
    .in_alloc_bytes  (in_alloc_bytes),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take)
  );

  // table scan and accounting
  aut_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_take             (cmd_take),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_total_bytes      (out_total_bytes),
    .out_peak_bytes       (out_peak_bytes),
    .out_over_limit_event (out_over_limit_event),
    .out_handle_found     (out_handle_found),
    .out_table_overflow   (out_table_overflow)
  );

endmodule

// ===== dv/allocation_usage_tracker_core_tb.sv =====
// ----------------------------------------------------------------------------
// allocation_usage_tracker_core_tb
// Self-checking bench for the allocation usage tracker. A directed opening
// walks the null and unknown handle cases, duplicates, the limit edge and
// saturation. Randomized phases then run over a fixed handle pool under
// different soft limits, so the table fills, overflows and drains. The sender
// works in bursts, and the result side stalls on its own pattern with one
// long hold-off. A scoreboard class predicts every result.
// ----------------------------------------------------------------------------
module allocation_usage_tracker_core_tb;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 6;
  localparam int ITEM_CYCLES = aut_pkg::TABLE_ENTRIES + 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 600;
  localparam int HOLD_AFTER = 500;
  localparam int PHASE_ITEMS = 220;
  localparam int POOL_SIZE = 80;

  localparam bit MODE_ALLOC = 1'b0;
  localparam bit MODE_FREE = 1'b1;

  localparam logic [aut_pkg::BYTE_BITS-1:0] BYTES_MAX = '1;

  // one result transaction
  typedef struct packed {
    logic [aut_pkg::BYTE_BITS-1:0] total;
    logic [aut_pkg::BYTE_BITS-1:0] peak;
    logic                          warn;
    logic                          found;
    logic                          ovf;
  } usage_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the handle table and the totals
  // --------------------------------------------------------------------------
  class usage_scoreboard;
    logic [aut_pkg::HANDLE_BITS-1:0] entry_handle [aut_pkg::TABLE_ENTRIES];
    logic [aut_pkg::BYTE_BITS-1:0]   entry_size [aut_pkg::TABLE_ENTRIES];
    bit                              entry_live [aut_pkg::TABLE_ENTRIES];
    logic [aut_pkg::BYTE_BITS-1:0]   held;
    logic [aut_pkg::BYTE_BITS-1:0]   peak;
    logic [aut_pkg::BYTE_BITS-1:0]   limit;
    bit                              warned;
    usage_t                          expected_usage [$];
    int unsigned                     errors, n_out, n_alloc, n_freed, n_ignored;
    int unsigned                     n_ovf, n_warn, n_sat;

    function new();
      int i;
      for (i = 0; i < aut_pkg::TABLE_ENTRIES; i++) entry_live[i] = 1'b0;
      held = '0;
      peak = '0;
      limit = '0;
      warned = 1'b0;
    endfunction

    // limit write also re-arms the one-shot
    function void arm_limit(logic [aut_pkg::BYTE_BITS-1:0] v);
      limit = v;
      warned = 1'b0;
    endfunction

    function int pending();
      return expected_usage.size();
    endfunction

    // lowest live slot holding h, -1 if none
    function int lookup(logic [aut_pkg::HANDLE_BITS-1:0] h);
      int i;
      for (i = 0; i < aut_pkg::TABLE_ENTRIES; i++)
        if (entry_live[i] && entry_handle[i] == h) return i;
      return -1;
    endfunction

    // accepted request: update the mirror and queue the expected result
    function void note_request(bit mode, logic [aut_pkg::HANDLE_BITS-1:0] h,
                               logic [aut_pkg::BYTE_BITS-1:0] b);
      usage_t                      r;
      int                          slot;
      int                          i;
      logic [aut_pkg::BYTE_BITS:0] sum;
      r = '0;
      if (mode == MODE_ALLOC) begin
        n_alloc++;
        slot = lookup(h);
        if (slot >= 0) begin
          r.found = 1'b1;
        end else begin
          for (i = 0; i < aut_pkg::TABLE_ENTRIES; i++)
            if (!entry_live[i] && slot < 0) slot = i;
        end
        if (slot >= 0) begin
          entry_handle[slot] = h;
          entry_size[slot] = b;
          entry_live[slot] = 1'b1;
        end else begin
          r.ovf = 1'b1;
          n_ovf++;
        end
        // saturating add
        sum = {1'b0, held} + {1'b0, b};
        if (sum[aut_pkg::BYTE_BITS]) begin
          held = BYTES_MAX;
          n_sat++;
        end else begin
          held = sum[aut_pkg::BYTE_BITS-1:0];
        end
        if (held > peak) peak = held;
        if (limit != '0 && held > limit && !warned) begin
          warned = 1'b1;
          r.warn = 1'b1;
          n_warn++;
        end
      end else if (h != '0) begin
        slot = lookup(h);
        if (slot >= 0) begin
          r.found = 1'b1;
          n_freed++;
          held = (entry_size[slot] >= held) ? '0 : held - entry_size[slot];
          entry_live[slot] = 1'b0;
        end else begin
          n_ignored++;
        end
      end else begin
        n_ignored++;
      end
      r.total = held;
      r.peak = peak;
      expected_usage.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one popped result with the oldest expectation
    task check_result(usage_t got);
      usage_t want;
      if (expected_usage.size() == 0) begin
        report($sformatf("result with nothing pending, total %h", got.total));
        return;
      end
      want = expected_usage.pop_front();
      n_out++;
      if (got.total !== want.total)
        report($sformatf("result %0d total %h, want %h", n_out, got.total, want.total));
      if (got.peak !== want.peak)
        report($sformatf("result %0d peak %h, want %h", n_out, got.peak, want.peak));
      if (got.warn !== want.warn)
        report($sformatf("result %0d over_limit %b, want %b", n_out, got.warn, want.warn));
      if (got.found !== want.found)
        report($sformatf("result %0d found %b, want %b", n_out, got.found, want.found));
      if (got.ovf !== want.ovf)
        report($sformatf("result %0d overflow %b, want %b", n_out, got.ovf, want.ovf));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic                            in_full;
  logic                            in_mode = MODE_ALLOC;
  logic [aut_pkg::HANDLE_BITS-1:0] in_alloc_handle = '0;
  logic [aut_pkg::BYTE_BITS-1:0]   in_alloc_bytes = '0;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  logic [aut_pkg::BYTE_BITS-1:0]   out_total_bytes;
  logic [aut_pkg::BYTE_BITS-1:0]   out_peak_bytes;
  logic                            out_over_limit_event;
  logic                            out_handle_found;
  logic                            out_table_overflow;
  logic                            cfg_wr_en = 1'b0;
  logic [aut_pkg::BYTE_BITS-1:0]   cfg_wr_data = '0;

  usage_scoreboard                 sb = new();
  logic [aut_pkg::HANDLE_BITS-1:0] handle_pool [POOL_SIZE];
  int                              cycle_count = 0;

  allocation_usage_tracker_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_mode              (in_mode),
    .in_alloc_handle      (in_alloc_handle),
    .in_alloc_bytes       (in_alloc_bytes),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_total_bytes      (out_total_bytes),
    .out_peak_bytes       (out_peak_bytes),
    .out_over_limit_event (out_over_limit_event),
    .out_handle_found     (out_handle_found),
    .out_table_overflow   (out_table_overflow),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
      $display("allocation_usage_tracker_core_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // input side tasks
  // --------------------------------------------------------------------------
  // offer one transaction; returns on the edge that accepts it, push left high
  task automatic push_item(bit mode, logic [aut_pkg::HANDLE_BITS-1:0] h,
                           logic [aut_pkg::BYTE_BITS-1:0] b);
    in_push <= 1'b1;
    in_mode <= mode;
    in_alloc_handle <= h;
    in_alloc_bytes <= b;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.note_request(mode, h, b);
  endtask

  // stop offering and wait for every result, then let the block settle
  task automatic wait_drained();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (ITEM_CYCLES) @(posedge clk);
  endtask

  task automatic set_soft_limit(logic [aut_pkg::BYTE_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.arm_limit(v);
    cfg_wr_en <= 1'b0;
  endtask

  // random traffic over the handle pool; free_pct steers table occupancy
  task automatic run_phase(logic [aut_pkg::BYTE_BITS-1:0] limit, int unsigned free_pct,
                           int unsigned count);
    int unsigned                     sent;
    int unsigned                     burst;
    int unsigned                     roll;
    int unsigned                     size_roll;
    bit                              mode;
    logic [aut_pkg::HANDLE_BITS-1:0] h;
    logic [aut_pkg::BYTE_BITS-1:0]   b;
    logic [63:0]                     wide;
    set_soft_limit(limit);
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        sent++;
        wide = {$urandom, $urandom};
        size_roll = $urandom_range(0, 99);
        if (size_roll < 80) b = aut_pkg::BYTE_BITS'($urandom_range(0, 4095));
        else if (size_roll < 95) b = {16'h0, $urandom};
        else if (size_roll < 99) b = wide[aut_pkg::BYTE_BITS-1:0];
        else b = BYTES_MAX;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          // null free
          mode = MODE_FREE;
          h = '0;
        end else if (roll < 6) begin
          // free of a handle never allocated
          mode = MODE_FREE;
          h = {$urandom, $urandom};
        end else if (roll < 8) begin
          mode = MODE_ALLOC;
          h = '0;
        end else if (roll < 8 + free_pct) begin
          mode = MODE_FREE;
          h = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          mode = MODE_ALLOC;
          h = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        push_item(mode, h, b);
      end
      // gap between bursts, sometimes none
      if ($urandom_range(0, 3) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // result side: pops on a changing stall pattern, one long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_side
    int unsigned style;
    int unsigned stretch;
    int unsigned hold_left;
    bit          held_once;
    usage_t      got;
    style = 0;
    stretch = 0;
    hold_left = 0;
    held_once = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_pop && out_empty === 1'b0) begin
        got.total = out_total_bytes;
        got.peak = out_peak_bytes;
        got.warn = out_over_limit_event;
        got.found = out_handle_found;
        got.ovf = out_table_overflow;
        sb.check_result(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (!held_once && sb.n_out >= HOLD_AFTER) begin
        // long hold-off so the input side backs up
        held_once = 1'b1;
        hold_left = LONG_HOLD;
        out_pop <= 1'b0;
      end else begin
        if (stretch == 0) begin
          style = $urandom_range(0, 3);
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        case (style)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          2: out_pop <= ($urandom_range(0, 7) == 0);
          default: out_pop <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          i;
    logic [63:0] wide;
    for (i = 0; i < POOL_SIZE; i++) handle_pool[i] = {$urandom, $urandom};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: null and unknown frees, limit edge, duplicate, saturation
    set_soft_limit(48'd100);
    push_item(MODE_FREE, '0, BYTES_MAX);
    push_item(MODE_FREE, '1, '0);
    push_item(MODE_ALLOC, '0, '0);
    push_item(MODE_ALLOC, '1, 48'd50);
    push_item(MODE_ALLOC, 64'd1, 48'd50);   // total equals limit, no event
    push_item(MODE_ALLOC, 64'd2, 48'd1);    // first crossing
    push_item(MODE_ALLOC, 64'd3, 48'd10);   // already warned
    push_item(MODE_ALLOC, '1, 48'd5);       // duplicate, full size added
    push_item(MODE_FREE, '1, BYTES_MAX);    // takes back the new size only
    push_item(MODE_FREE, '1, '0);           // gone now
    push_item(MODE_FREE, '0, '0);           // null slot is live but never freed
    push_item(MODE_ALLOC, 64'd4, BYTES_MAX);
    push_item(MODE_ALLOC, 64'd5, 48'd7);    // stays saturated
    push_item(MODE_FREE, 64'd4, '0);        // floors at zero
    push_item(MODE_FREE, 64'd1, '0);        // floor again from zero
    push_item(MODE_ALLOC, 64'h8000_0000_0000_0000, 48'h8000_0000_0000);
    push_item(MODE_FREE, 64'h8000_0000_0000_0000, '0);
    push_item(MODE_FREE, 64'd2, '0);
    push_item(MODE_FREE, 64'd3, '0);
    push_item(MODE_FREE, 64'd5, '0);
    push_item(MODE_ALLOC, 64'h5555_aaaa_5555_aaaa, 48'haaaa_5555_aaaa);
    push_item(MODE_FREE, 64'h5555_aaaa_5555_aaaa, 48'h5555_aaaa_5555);
    wait_drained();

    // random phases: fill and overflow, drain, tight limit, wide limits
    run_phase('0, 15, PHASE_ITEMS);
    run_phase(BYTES_MAX, 55, PHASE_ITEMS);
    run_phase(48'd1, 30, PHASE_ITEMS);
    wide = {$urandom, $urandom};
    run_phase(wide[aut_pkg::BYTE_BITS-1:0], 10, PHASE_ITEMS);
    run_phase(aut_pkg::BYTE_BITS'($urandom_range(5000, 200000)), 45, PHASE_ITEMS);

    repeat (ITEM_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("run: %0d results, %0d allocs, %0d live frees, %0d ignored frees",
             sb.n_out, sb.n_alloc, sb.n_freed, sb.n_ignored);
    $display("run: %0d overflows, %0d limit events, %0d saturating adds, %0d cycles",
             sb.n_ovf, sb.n_warn, sb.n_sat, cycle_count);
    if (sb.errors == 0) begin
      $display("allocation_usage_tracker_core_tb: clean");
    end else begin
      $display("allocation_usage_tracker_core_tb: errors");
    end
    $finish;
  end

endmodule
